@@ design/mclp_pkg.sv @@
// shared types and constants for the multi-click long-press detector
// no dependencies; used by every module of the block
package mclp_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int STAMP_W       = 32;
    localparam int MS_W          = 16;
    localparam int COUNT_W       = 4;
    localparam int TALLY_W       = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 16;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 8'hFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLICKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_TIMEOUT = 3'd4;

    localparam logic [MS_W-1:0]    DEBOUNCE_RST    = 16'd50;
    localparam logic [MS_W-1:0]    CLICK_GAP_RST   = 16'd500;
    localparam logic [COUNT_W-1:0] CLICKS_RST      = 4'd3;
    localparam logic [MS_W-1:0]    HOLD_RST        = 16'd2000;
    localparam logic [MS_W-1:0]    ARM_TIMEOUT_RST = 16'd5000;

    // beat kinds carried on s_tuser
    localparam logic ACT_CLICK = 1'b0;
    localparam logic ACT_POLL  = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0]    debounce_ms;
        logic [MS_W-1:0]    click_gap_ms;
        logic [COUNT_W-1:0] clicks_needed;
        logic [MS_W-1:0]    hold_ms;
        logic [MS_W-1:0]    arm_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] event_time;
        logic               pin_low;
    } item_t;

    typedef struct packed {
        logic               pattern_complete;
        logic               armed;
        logic [TALLY_W-1:0] click_total;
    } result_t;

endpackage

@@ design/mclp_cfg.sv @@
// configuration register bank of the multi-click long-press detector
// depends on mclp_pkg
module mclp_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mclp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mclp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mclp_pkg::cfg_t                    cfg
);

    mclp_pkg::cfg_t cfg_reg;
    mclp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mclp_pkg::REG_DEBOUNCE:    cfg_next.debounce_ms    = cfg_data;
                mclp_pkg::REG_CLICK_GAP:   cfg_next.click_gap_ms   = cfg_data;
                mclp_pkg::REG_CLICKS:
                    cfg_next.clicks_needed = cfg_data[mclp_pkg::COUNT_W-1:0];
                mclp_pkg::REG_HOLD:        cfg_next.hold_ms        = cfg_data;
                mclp_pkg::REG_ARM_TIMEOUT: cfg_next.arm_timeout_ms = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms    <= mclp_pkg::DEBOUNCE_RST;
            cfg_reg.click_gap_ms   <= mclp_pkg::CLICK_GAP_RST;
            cfg_reg.clicks_needed  <= mclp_pkg::CLICKS_RST;
            cfg_reg.hold_ms        <= mclp_pkg::HOLD_RST;
            cfg_reg.arm_timeout_ms <= mclp_pkg::ARM_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/mclp_core.sv @@
// gesture state and its single-pass update for one beat
// depends on mclp_pkg
module mclp_core
#(
    parameter int TIME_BITS = mclp_pkg::TIME_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  mclp_pkg::item_t   item,
    input  mclp_pkg::cfg_t    cfg,
    output mclp_pkg::result_t res
);

    logic [mclp_pkg::TALLY_W-1:0] tally_reg, tally_next;
    logic [TIME_BITS-1:0]         last_click_reg, last_click_next;
    logic                         arm_reg, arm_next;
    logic [TIME_BITS-1:0]         arm_stamp_reg, arm_stamp_next;
    logic [TIME_BITS-1:0]         hold_start_reg, hold_start_next;
    logic                         hold_reg, hold_next;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] held_for;
    logic [TIME_BITS-1:0] since_arm;
    logic                 done;
    logic                 finished;

    assign now       = TIME_BITS'(item.event_time);
    assign gap       = now - last_click_reg;
    assign held_for  = now - hold_start_reg;
    assign since_arm = now - arm_stamp_reg;

    always_comb
    begin
        tally_next      = tally_reg;
        last_click_next = last_click_reg;
        arm_next        = arm_reg;
        arm_stamp_next  = arm_stamp_reg;
        hold_start_next = hold_start_reg;
        hold_next       = hold_reg;
        done            = 1'b0;
        finished        = 1'b0;

        if (item.action == mclp_pkg::ACT_CLICK)
        begin
            if (gap >= TIME_BITS'(cfg.debounce_ms))
            begin
                if (gap > TIME_BITS'(cfg.click_gap_ms))
                    tally_next = mclp_pkg::TALLY_W'(1);
                else if (tally_reg != mclp_pkg::TALLY_MAX)
                    tally_next = tally_reg + mclp_pkg::TALLY_W'(1);
                last_click_next = now;
                if (tally_next == mclp_pkg::TALLY_W'(cfg.clicks_needed))
                begin
                    arm_next       = 1'b1;
                    arm_stamp_next = now;
                end
            end
        end
        else if (arm_reg)
        begin
            if (item.pin_low)
            begin
                if (!hold_reg)
                begin
                    hold_next       = 1'b1;
                    hold_start_next = now;
                end
                else if (held_for >= TIME_BITS'(cfg.hold_ms))
                begin
                    arm_next   = 1'b0;
                    hold_next  = 1'b0;
                    tally_next = '0;
                    done       = 1'b1;
                    finished   = 1'b1;
                end
            end
            else
            begin
                hold_next = 1'b0;
            end
            // abandon the gesture once the arm window has run out
            if (!finished && since_arm > TIME_BITS'(cfg.arm_timeout_ms))
            begin
                arm_next   = 1'b0;
                hold_next  = 1'b0;
                tally_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg      <= '0;
            last_click_reg <= '0;
            arm_reg        <= 1'b0;
            arm_stamp_reg  <= '0;
            hold_start_reg <= '0;
            hold_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            tally_reg      <= tally_next;
            last_click_reg <= last_click_next;
            arm_reg        <= arm_next;
            arm_stamp_reg  <= arm_stamp_next;
            hold_start_reg <= hold_start_next;
            hold_reg       <= hold_next;
        end
    end

    assign res.pattern_complete = done;
    assign res.armed            = arm_next;
    assign res.click_total      = tally_next;

endmodule

@@ design/multi_click_long_press_detector.sv @@
// top level of the multi-click long-press detector: stream ports and beat stages
// depends on mclp_pkg, mclp_cfg and mclp_core
//
// Recognises a run of button clicks followed by a long press. Each input beat is
// a click event or a poll (s_tuser) with a millisecond timestamp and the pin
// level; each beat yields exactly one result beat giving pattern_complete, the
// armed flag and the click count after that beat. A beat passes an input
// register, the state update and a result register, so m_tvalid rises once the
// beat reaches the result register, which a stalled sink can delay; the block
// sustains one beat per cycle and only a stalled sink holds the input back. The
// state update is the only stage that holds gesture state. Time differences wrap
// modulo 2^TIME_BITS. Configuration writes take effect at the next clock and are
// meant to be made while no beat is in flight. Reset sets all state but the
// beat data registers at once; there is no start-up sweep.
module multi_click_long_press_detector
#(
    parameter int TIME_BITS = mclp_pkg::TIME_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mclp_pkg::S_TDATA_W-1:0]    s_tdata,  // event_time[31:0], pin_low[32]
    input  logic                              s_tuser,  // action (0 click, 1 poll)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pattern_complete[0], armed[1], click_total[9:2]
    output logic [mclp_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [mclp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mclp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mclp_pkg::cfg_t    cfg;
    mclp_pkg::item_t   in_item_reg;
    mclp_pkg::item_t   in_item_next;
    logic              in_valid_reg;
    mclp_pkg::result_t res;
    mclp_pkg::result_t out_res_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              s_beat;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    assign in_item_next.action     = s_tuser;
    assign in_item_next.event_time = s_tdata[mclp_pkg::STAMP_W-1:0];
    assign in_item_next.pin_low    = s_tdata[mclp_pkg::STAMP_W];

    mclp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mclp_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_beat)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
            in_item_reg <= in_item_next;
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mclp_pkg::M_TDATA_W'({out_res_reg.click_total, out_res_reg.armed,
                                            out_res_reg.pattern_complete});

    // a completing poll always leaves the gesture cleared
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_res_reg.pattern_complete |->
            !out_res_reg.armed && out_res_reg.click_total == '0)
        else $error("completion beat did not clear the gesture");

    // the wait is only armed after at least one counted click
    a_armed_has_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_res_reg.armed |-> out_res_reg.click_total != '0)
        else $error("armed with zero clicks");

    // input side only stalls when both stages are full and the sink is stalling
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without back-pressure");

endmodule
